@@ rtl/sdgr_pkg.sv @@
package sdgr_pkg;

    localparam int SCREEN_COLUMNS = 128;
    localparam int SCREEN_ROWS    = 64;
    localparam int MAX_SCALE      = 4;

    localparam int PAGE_COUNT  = (SCREEN_ROWS + 7) / 8;
    localparam int STORE_BYTES = SCREEN_COLUMNS * PAGE_COUNT;
    localparam int ADDR_W      = $clog2(STORE_BYTES);
    localparam int BYTE_W      = 8;

    localparam int POS_X_W = 7;
    localparam int POS_Y_W = 6;

    localparam int GLYPH_COLS = 5;
    localparam int GLYPH_ROWS = 7;
    localparam int GC_W       = $clog2(GLYPH_COLS);
    localparam int GR_W       = 3;
    localparam int SC_W       = $clog2(MAX_SCALE + 1);
    localparam int COL_W      = $clog2((1 << POS_X_W) + GLYPH_COLS * MAX_SCALE);
    localparam int ROW_W      = $clog2((1 << POS_Y_W) + GLYPH_ROWS * MAX_SCALE);

    localparam logic [1:0] ACT_CLEAR = 2'd0;
    localparam logic [1:0] ACT_DRAW  = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    localparam logic [3:0] LAST_DIGIT = 4'd9;

    localparam logic [BYTE_W-1:0] FONT [0:9][0:4] = '{
        '{8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E},
        '{8'h00, 8'h42, 8'h7F, 8'h40, 8'h00},
        '{8'h42, 8'h61, 8'h51, 8'h49, 8'h46},
        '{8'h21, 8'h41, 8'h45, 8'h4B, 8'h31},
        '{8'h18, 8'h14, 8'h12, 8'h7F, 8'h10},
        '{8'h27, 8'h45, 8'h45, 8'h45, 8'h39},
        '{8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30},
        '{8'h01, 8'h71, 8'h09, 8'h05, 8'h03},
        '{8'h36, 8'h49, 8'h49, 8'h49, 8'h36},
        '{8'h06, 8'h49, 8'h49, 8'h29, 8'h1E}
    };

    function automatic logic [BYTE_W-1:0] font_col(input logic [3:0] digit,
                                                   input logic [GC_W-1:0] col);
        logic [BYTE_W-1:0] bits;
        bits = '0;
        if (digit <= LAST_DIGIT && 32'(col) < GLYPH_COLS) begin
            bits = FONT[digit][col];
        end
        return bits;
    endfunction

    typedef struct packed {
        logic              rd;
        logic              wr;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] wdata;
    } t_mem_req;

    typedef struct packed {
        logic start;
        logic advance;
    } t_scan_ctl;

    typedef struct packed {
        logic              hit;
        logic              last;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] mask;
    } t_scan_sts;

endpackage

@@ rtl/sdgr_frame_mem.sv @@
module sdgr_frame_mem (
    input  logic                           i_clk,
    input  sdgr_pkg::t_mem_req             i_req,
    output logic [sdgr_pkg::BYTE_W-1:0]    o_rdata
);

    logic [sdgr_pkg::BYTE_W-1:0] r_store [sdgr_pkg::STORE_BYTES];
    logic [sdgr_pkg::BYTE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.wr) begin
            r_store[i_req.addr] <= i_req.wdata;
        end
        if (i_req.rd) begin
            r_rdata <= r_store[i_req.addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/sdgr_pixel_scan.sv @@
module sdgr_pixel_scan (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  sdgr_pkg::t_scan_ctl               i_ctl,
    input  logic [sdgr_pkg::POS_X_W-1:0]      i_pos_x,
    input  logic [sdgr_pkg::POS_Y_W-1:0]      i_pos_y,
    input  logic [3:0]                        i_digit,
    input  logic [sdgr_pkg::SC_W-1:0]         i_scale,
    output sdgr_pkg::t_scan_sts               o_sts
);

    logic                          r_run;
    logic [sdgr_pkg::ROW_W-1:0]    r_y;
    logic [3:0]                    r_digit;
    logic [sdgr_pkg::SC_W-1:0]     r_scale;
    logic [sdgr_pkg::GC_W-1:0]     r_c;
    logic [sdgr_pkg::GR_W-1:0]     r_r;
    logic [sdgr_pkg::SC_W-1:0]     r_dx;
    logic [sdgr_pkg::SC_W-1:0]     r_dy;
    logic [sdgr_pkg::COL_W-1:0]    r_col;
    logic [sdgr_pkg::ROW_W-1:0]    r_row;

    logic [sdgr_pkg::BYTE_W-1:0]   font_bits;
    logic                          in_screen;
    logic                          dy_wrap;
    logic                          glyph_row_wrap;
    logic                          dx_wrap;
    logic                          c_last;
    logic [sdgr_pkg::ROW_W-4:0]    page;

    always_comb begin
        font_bits = sdgr_pkg::font_col(r_digit, r_c);
        in_screen = (32'(r_col) < sdgr_pkg::SCREEN_COLUMNS)
                 && (32'(r_row) < sdgr_pkg::SCREEN_ROWS);
        dy_wrap   = sdgr_pkg::SC_W'(r_dy + 1'b1) == r_scale;
        dx_wrap   = sdgr_pkg::SC_W'(r_dx + 1'b1) == r_scale;
        glyph_row_wrap = r_r == sdgr_pkg::GR_W'(sdgr_pkg::GLYPH_ROWS - 1);
        c_last    = r_c == sdgr_pkg::GC_W'(sdgr_pkg::GLYPH_COLS - 1);
        page      = r_row[sdgr_pkg::ROW_W-1:3];

        o_sts.hit  = r_run && font_bits[r_r] && in_screen;
        o_sts.last = r_run && dy_wrap && glyph_row_wrap && dx_wrap && c_last;
        o_sts.addr = sdgr_pkg::ADDR_W'(r_col)
                   + sdgr_pkg::ADDR_W'(32'(page) * sdgr_pkg::SCREEN_COLUMNS);
        o_sts.mask = sdgr_pkg::BYTE_W'(1) << r_row[2:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
        end else if (i_ctl.start) begin
            r_run <= 1'b1;
        end else if (i_ctl.advance && o_sts.last) begin
            r_run <= 1'b0;
        end
    end

    // walk order: dy inside r inside dx inside c
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_y     <= sdgr_pkg::ROW_W'(i_pos_y);
            r_digit <= i_digit;
            r_scale <= i_scale;
            r_c     <= '0;
            r_r     <= '0;
            r_dx    <= '0;
            r_dy    <= '0;
            r_col   <= sdgr_pkg::COL_W'(i_pos_x);
            r_row   <= sdgr_pkg::ROW_W'(i_pos_y);
        end else if (i_ctl.advance && r_run) begin
            if (!dy_wrap) begin
                r_dy  <= sdgr_pkg::SC_W'(r_dy + 1'b1);
                r_row <= sdgr_pkg::ROW_W'(r_row + 1'b1);
            end else if (!glyph_row_wrap) begin
                r_dy  <= '0;
                r_r   <= sdgr_pkg::GR_W'(r_r + 1'b1);
                r_row <= sdgr_pkg::ROW_W'(r_row + 1'b1);
            end else begin
                r_dy  <= '0;
                r_r   <= '0;
                r_row <= r_y;
                r_col <= sdgr_pkg::COL_W'(r_col + 1'b1);
                if (!dx_wrap) begin
                    r_dx <= sdgr_pkg::SC_W'(r_dx + 1'b1);
                end else begin
                    r_dx <= '0;
                    r_c  <= sdgr_pkg::GC_W'(r_c + 1'b1);
                end
            end
        end
    end

endmodule

@@ rtl/scaled_digit_glyph_renderer.sv @@
// channel   direction  handshake                 payload
// input     in         i_in_valid / o_in_stall   action, pos_x, pos_y, digit_value,
//                                                scale_factor, read_index
// output    out        o_out_valid / i_out_stall read_data, digit_rejected
//
// read goes through S_RRD and S_DONE; clear writes the whole framebuffer, one byte per cycle
// draw walks 35*s*s pixel steps, one per cycle except while a byte read-modify-write
// (S_FRD then S_FWR) is in progress, and writes back the last pending byte after the walk
// after reset the framebuffer is wiped with o_in_stall high
// o_in_stall is high while an item is in work; a waiting result does not block
// the next beat, which is held only once its own result is ready
module scaled_digit_glyph_renderer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_action,
    input  logic [6:0]  i_pos_x,
    input  logic [5:0]  i_pos_y,
    input  logic [3:0]  i_digit_value,
    input  logic [2:0]  i_scale_factor,
    input  logic [9:0]  i_read_index,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_read_data,
    output logic        o_digit_rejected
);

    typedef enum logic [6:0] {
        S_WIPE = 7'b0000001,
        S_IDLE = 7'b0000010,
        S_SCAN = 7'b0000100,
        S_FRD  = 7'b0001000,
        S_FWR  = 7'b0010000,
        S_RRD  = 7'b0100000,
        S_DONE = 7'b1000000
    } t_state;

    t_state                          r_state, n_state;
    logic                            r_boot, n_boot;
    logic [sdgr_pkg::ADDR_W-1:0]     r_wipe, n_wipe;
    logic                            r_pend, n_pend;
    logic [sdgr_pkg::ADDR_W-1:0]     r_addr, n_addr;
    logic [sdgr_pkg::BYTE_W-1:0]     r_mask, n_mask;
    logic                            r_fin, n_fin;
    logic                            r_rd_ok, n_rd_ok;
    logic [sdgr_pkg::BYTE_W-1:0]     r_res_data, n_res_data;
    logic                            r_res_rej, n_res_rej;
    logic                            r_out_valid;
    logic [sdgr_pkg::BYTE_W-1:0]     r_out_data;
    logic                            r_out_rej;

    sdgr_pkg::t_mem_req              mem_req;
    sdgr_pkg::t_scan_ctl             scan_ctl;
    sdgr_pkg::t_scan_sts             scan_sts;
    logic [sdgr_pkg::BYTE_W-1:0]     mem_rdata;
    logic [sdgr_pkg::SC_W-1:0]       scale_sat;
    logic                            in_accept;
    logic                            out_free;
    logic                            flush;

    assign in_accept = i_in_valid && (r_state == S_IDLE);
    assign out_free  = !r_out_valid || !i_out_stall;
    assign scale_sat = (32'(i_scale_factor) > sdgr_pkg::MAX_SCALE)
                     ? sdgr_pkg::SC_W'(sdgr_pkg::MAX_SCALE)
                     : sdgr_pkg::SC_W'(i_scale_factor);
    assign flush     = scan_sts.hit && r_pend && (scan_sts.addr != r_addr);

    sdgr_frame_mem u_mem (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    sdgr_pixel_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (scan_ctl),
        .i_pos_x (i_pos_x),
        .i_pos_y (i_pos_y),
        .i_digit (i_digit_value),
        .i_scale (scale_sat),
        .o_sts   (scan_sts)
    );

    always_comb begin
        n_state    = r_state;
        n_boot     = r_boot;
        n_wipe     = r_wipe;
        n_pend     = r_pend;
        n_addr     = r_addr;
        n_mask     = r_mask;
        n_fin      = r_fin;
        n_rd_ok    = r_rd_ok;
        n_res_data = r_res_data;
        n_res_rej  = r_res_rej;
        mem_req    = '0;
        scan_ctl   = '0;

        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_res_data = '0;
                    n_res_rej  = 1'b0;
                    case (i_action)
                        sdgr_pkg::ACT_CLEAR: begin
                            n_wipe  = '0;
                            n_state = S_WIPE;
                        end
                        sdgr_pkg::ACT_DRAW: begin
                            if (i_digit_value > sdgr_pkg::LAST_DIGIT) begin
                                n_res_rej = 1'b1;
                                n_state   = S_DONE;
                            end else if (scale_sat == '0) begin
                                n_state = S_DONE;
                            end else begin
                                scan_ctl.start = 1'b1;
                                n_pend  = 1'b0;
                                n_mask  = '0;
                                n_fin   = 1'b0;
                                n_state = S_SCAN;
                            end
                        end
                        sdgr_pkg::ACT_READ: begin
                            mem_req.rd   = 1'b1;
                            mem_req.addr = sdgr_pkg::ADDR_W'(i_read_index);
                            n_rd_ok      = 32'(i_read_index) < sdgr_pkg::STORE_BYTES;
                            n_state      = S_RRD;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_WIPE: begin
                mem_req.wr    = 1'b1;
                mem_req.addr  = r_wipe;
                mem_req.wdata = '0;
                n_wipe        = sdgr_pkg::ADDR_W'(r_wipe + 1'b1);
                if (r_wipe == sdgr_pkg::ADDR_W'(sdgr_pkg::STORE_BYTES - 1)) begin
                    n_boot  = 1'b0;
                    n_state = r_boot ? S_IDLE : S_DONE;
                end
            end
            S_SCAN: begin
                if (flush) begin
                    n_state = S_FRD;
                end else begin
                    scan_ctl.advance = 1'b1;
                    if (scan_sts.hit) begin
                        n_pend = 1'b1;
                        n_addr = scan_sts.addr;
                        n_mask = r_mask | scan_sts.mask;
                    end
                    if (scan_sts.last) begin
                        n_fin   = 1'b1;
                        n_state = (r_pend || scan_sts.hit) ? S_FRD : S_DONE;
                    end
                end
            end
            S_FRD: begin
                mem_req.rd   = 1'b1;
                mem_req.addr = r_addr;
                n_state      = S_FWR;
            end
            S_FWR: begin
                mem_req.wr    = 1'b1;
                mem_req.addr  = r_addr;
                mem_req.wdata = mem_rdata | r_mask;
                n_pend        = 1'b0;
                n_mask        = '0;
                n_state       = r_fin ? S_DONE : S_SCAN;
            end
            S_RRD: begin
                n_res_data = r_rd_ok ? mem_rdata : '0;
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_WIPE;
            r_boot  <= 1'b1;
            r_wipe  <= '0;
            r_pend  <= 1'b0;
            r_fin   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_boot  <= n_boot;
            r_wipe  <= n_wipe;
            r_pend  <= n_pend;
            r_fin   <= n_fin;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr     <= n_addr;
        r_mask     <= n_mask;
        r_rd_ok    <= n_rd_ok;
        r_res_data <= n_res_data;
        r_res_rej  <= n_res_rej;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && out_free) begin
            r_out_data <= r_res_data;
            r_out_rej  <= r_res_rej;
        end
    end

    assign o_in_stall       = r_state != S_IDLE;
    assign o_out_valid      = r_out_valid;
    assign o_read_data      = r_out_data;
    assign o_digit_rejected = r_out_rej;

endmodule

@@ rtl/sdgr_port_checker.sv @@
module sdgr_port_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [7:0]  i_read_data,
    input  logic        i_digit_rejected
);

    // framebuffer wipe holds off input beats right after reset
    a_wipe_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> i_in_stall)
        else $error("input not stalled after reset");

    // one item in work at a time
    a_busy_after_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !i_in_stall |=> i_in_stall)
        else $error("input beat taken while busy");

    // a rejected draw never carries read data
    a_reject_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_digit_rejected |-> i_read_data == 8'd0)
        else $error("rejected result with read data");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=>
            i_out_valid && $stable(i_read_data) && $stable(i_digit_rejected))
        else $error("stalled result changed");

endmodule

bind scaled_digit_glyph_renderer sdgr_port_checker u_port_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .i_in_stall       (o_in_stall),
    .i_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .i_read_data      (o_read_data),
    .i_digit_rejected (o_digit_rejected)
);
